>>> hdl/ntps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ntps_pkg;

  localparam int MAX_POSES = 256;
  localparam int COORD_W   = 24;
  localparam int ADDR_W    = $clog2(MAX_POSES);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int IDX_W     = CNT_W + 1;
  localparam int DIST_W    = 49;
  localparam int MUL_W     = 26;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int NUM_W     = 2 * DIST_W;
  localparam int ACC_W     = NUM_W + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  // operation codes
  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_APPEND  = 3'd1;
  localparam logic [2:0] OP_POINT   = 3'd2;
  localparam logic [2:0] OP_SEGMENT = 3'd3;
  localparam logic [2:0] OP_REGION  = 3'd4;

  // register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_BEHIND = 2'd1;
  localparam logic [1:0] REG_SKIP   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_R0, S_R1, S_R2, S_R3,
    S_LN0, S_LN1, S_LN2,
    S_RD, S_LD,
    S_SQ0, S_SQ1, S_SQ2,
    S_SG0, S_SG1, S_SG2, S_SG3, S_SG4,
    S_CR0, S_CR1, S_CR2, S_CR3, S_DIV,
    S_HD0, S_HD1, S_HD2,
    S_DONE
  } ntps_state_t;

endpackage
`default_nettype wire

>>> hdl/ntps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ntps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> hdl/ntps_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ntps_div import ntps_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DIST_W-1:0] den,
  output logic                   done,
  output logic      [DIST_W-1:0] quo
);

  // restoring divider, one quotient bit a cycle
  logic [NUM_W-1:0]     n_r, n_nxt;
  logic [DIST_W-1:0]    r_r, r_nxt;
  logic [DIST_W-1:0]    q_r, q_nxt;
  logic [DIST_W-1:0]    den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIST_W:0]      r2;
  logic [DIST_W:0]      r_sub;
  logic                 ge;

  always_comb begin
    r2    = {r_r, n_r[NUM_W-1]};
    r_sub = r2 - {1'b0, den_r};
    ge    = r2 >= {1'b0, den_r};
    n_nxt    = n_r;
    r_nxt    = r_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = num;
      r_nxt    = '0;
      q_nxt    = '0;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt   = {n_r[NUM_W-2:0], 1'b0};
      r_nxt   = ge ? r_sub[DIST_W-1:0] : r2[DIST_W-1:0];
      q_nxt   = {q_r[DIST_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    n_r   <= n_nxt;
    r_r   <= r_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

>>> hdl/nearest_trajectory_pose_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Nearest trajectory pose search: holds up to 256 planar poses (signed Q16.8) and answers
// nearest-to-point, nearest-to-segment and region-check requests with squared distances
// (Q32.16). Clear, append and unknown operations, and queries with no pose to search, are
// answered at once, with the result registered at the accept edge. Queries walk the store
// through one shared 26x26 multiplier under a sequencer, reading one pose at a time from
// the pose memory, and the input is held off until the result is handed over. A segment
// query runs the 98-step bit-serial divider for each pose whose projection lands inside
// the segment; a region check stops at the first pose outside the radius and adds a
// behind test per pose when the behind check is on. The pose memory is not cleared
// after reset.
module nearest_trajectory_pose_search_top import ntps_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // point_x, point_y, end_x, end_y, start_index
  input  wire logic [103:0] in_tdata,
  // operation
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // best_index, best_distance_sq, inside_region, pose_count, overflow, zero fill
  output logic      [71:0]  out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic      [31:0]  cfg_prdata,
  output logic              cfg_pready
);

  // request fields
  logic signed [COORD_W-1:0] in_px, in_py, in_ex, in_ey;
  logic [7:0]                in_start;
  assign in_px    = in_tdata[23:0];
  assign in_py    = in_tdata[47:24];
  assign in_ex    = in_tdata[71:48];
  assign in_ey    = in_tdata[95:72];
  assign in_start = in_tdata[103:96];

  // configuration registers
  logic [23:0]        radius_r;
  logic signed [24:0] behind_r;
  logic [7:0]         skip_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      behind_r <= '1;
      skip_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_RADIUS: radius_r <= cfg_pwdata[23:0];
        REG_BEHIND: behind_r <= cfg_pwdata[24:0];
        REG_SKIP:   skip_r   <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_RADIUS: cfg_prdata = {8'd0, radius_r};
      REG_BEHIND: cfg_prdata = {{7{behind_r[24]}}, behind_r};
      REG_SKIP:   cfg_prdata = {24'd0, skip_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  ntps_state_t state_r, state_nxt;
  logic [2:0]                op_r, op_nxt;
  logic signed [COORD_W-1:0] px_r, py_r, ex_r, ey_r;
  logic signed [COORD_W-1:0] px_nxt, py_nxt, ex_nxt, ey_nxt;
  logic signed [COORD_W-1:0] qx_r, qy_r, qx_nxt, qy_nxt;
  logic signed [COORD_W-1:0] ax_r, ay_r, ax_nxt, ay_nxt;
  logic signed [COORD_W:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  logic [DIST_W-1:0]         len2_r, len2_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [PROD_W-1:0]  p_r, p_nxt;
  logic signed [50:0]        t_r, t_nxt;
  logic [DIST_W-1:0]         mag_r, mag_nxt;
  logic [DIST_W-1:0]         d_r, d_nxt;
  logic [47:0]               rad2_r, rad2_nxt, beh2_r, beh2_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [8:0]                best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0]         best_d_r, best_d_nxt;
  logic                      found_r, found_nxt;
  logic                      inside_r, inside_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [71:0]               out_data_r, out_data_nxt;

  // handshake
  logic accept, out_free, room;
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && out_free;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign room       = count_r < CNT_W'(MAX_POSES);

  // pose memory, x in the low half
  logic                       ram_we;
  logic [2*COORD_W-1:0]       ram_rdata;
  logic signed [COORD_W-1:0]  mem_x, mem_y;

  assign ram_we = accept && (in_tuser == OP_APPEND) && room;
  assign mem_x  = ram_rdata[COORD_W-1:0];
  assign mem_y  = ram_rdata[2*COORD_W-1:COORD_W];

  ntps_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POSES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata ({in_py, in_px}),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // divider for the perpendicular term
  logic              div_start, div_done;
  logic [DIST_W-1:0] div_quo;
  logic [ACC_W-1:0]  sum;

  ntps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum[NUM_W-1:0]),
    .den   (len2_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // shared operand terms
  logic signed [COORD_W:0]  vx, vy, wx, wy;
  logic signed [ACC_W-1:0]  pext, diff;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [23:0]              hpart;
  logic [24:0]              lpart;
  logic [DIST_W-1:0]        pose_d;
  logic [IDX_W-1:0]         idx_step;
  logic                     last, take, seg_near, seg_far, beh_en, far_out, behind_fail;

  assign vx    = {ax_r[COORD_W-1], ax_r} - {qx_r[COORD_W-1], qx_r};
  assign vy    = {ay_r[COORD_W-1], ay_r} - {qy_r[COORD_W-1], qy_r};
  assign wx    = {ax_r[COORD_W-1], ax_r} - {px_r[COORD_W-1], px_r};
  assign wy    = {ay_r[COORD_W-1], ay_r} - {py_r[COORD_W-1], py_r};
  assign pext  = {{(ACC_W-PROD_W){p_r[PROD_W-1]}}, p_r};
  assign sum   = acc_r + pext;
  assign diff  = acc_r - pext;
  assign hpart = mag_r[48:25];
  assign lpart = mag_r[24:0];
  assign beh_en = !behind_r[24];

  assign pose_d   = (state_r == S_DIV) ? div_quo : sum[DIST_W-1:0];
  assign take     = !found_r || (pose_d < best_d_r);
  assign idx_step = (op_r == OP_REGION) ? idx_r + IDX_W'(skip_r) + 1'b1 : idx_r + 1'b1;
  assign last     = idx_step >= IDX_W'(count_r);
  assign seg_near = (len2_r == '0) || t_r[50] || (t_r == '0);
  assign seg_far  = t_r[49:0] >= 50'(len2_r);
  assign far_out  = sum[DIST_W-1:0] > {1'b0, rad2_r};
  assign behind_fail = sum[ACC_W-1] && (d_r > {1'b0, beh2_r});

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_R1:  begin mul_a = {2'b0, radius_r}; mul_b = {2'b0, radius_r}; end
      S_R2:  begin mul_a = {behind_r[24], behind_r}; mul_b = {behind_r[24], behind_r}; end
      S_LN0: begin mul_a = {dx_r[24], dx_r}; mul_b = {dx_r[24], dx_r}; end
      S_LN1: begin mul_a = {dy_r[24], dy_r}; mul_b = {dy_r[24], dy_r}; end
      S_SQ0: begin mul_a = {vx[24], vx}; mul_b = {vx[24], vx}; end
      S_SQ1: begin mul_a = {vy[24], vy}; mul_b = {vy[24], vy}; end
      S_SG0: begin mul_a = {wx[24], wx}; mul_b = {dx_r[24], dx_r}; end
      S_SG1: begin mul_a = {wy[24], wy}; mul_b = {dy_r[24], dy_r}; end
      S_SG2: begin mul_a = {wx[24], wx}; mul_b = {dy_r[24], dy_r}; end
      S_SG3: begin mul_a = {wy[24], wy}; mul_b = {dx_r[24], dx_r}; end
      S_CR0: begin mul_a = {2'b0, hpart}; mul_b = {2'b0, hpart}; end
      S_CR1: begin mul_a = {2'b0, hpart}; mul_b = {1'b0, lpart}; end
      S_CR2: begin mul_a = {1'b0, lpart}; mul_b = {1'b0, lpart}; end
      S_HD0: begin mul_a = {vx[24], vx}; mul_b = {{2{px_r[23]}}, px_r}; end
      S_HD1: begin mul_a = {vy[24], vy}; mul_b = {{2{py_r[23]}}, py_r}; end
      default: ;
    endcase
  end

  assign p_nxt = mul_a * mul_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_tuser)
            OP_POINT:   if ({1'b0, in_start} < count_r) state_nxt = S_RD;
            OP_SEGMENT: if (count_r != '0) state_nxt = S_LN0;
            OP_REGION:  if (count_r != '0) state_nxt = S_R0;
            default: ;
          endcase
        end
      end
      S_R0:  state_nxt = S_R1;
      S_R1:  state_nxt = S_R2;
      S_R2:  state_nxt = S_R3;
      S_R3:  state_nxt = (count_r <= CNT_W'(1)) ? S_DONE : S_RD;
      S_LN0: state_nxt = S_LN1;
      S_LN1: state_nxt = S_LN2;
      S_LN2: state_nxt = S_RD;
      S_RD:  state_nxt = S_LD;
      S_LD:  state_nxt = (op_r == OP_SEGMENT) ? S_SG0 : S_SQ0;
      S_SQ0: state_nxt = S_SQ1;
      S_SQ1: state_nxt = S_SQ2;
      S_SQ2: begin
        if (op_r == OP_REGION) begin
          if (far_out)     state_nxt = S_DONE;
          else if (beh_en) state_nxt = S_HD0;
          else             state_nxt = last ? S_DONE : S_RD;
        end else begin
          state_nxt = last ? S_DONE : S_RD;
        end
      end
      S_SG0: state_nxt = S_SG1;
      S_SG1: state_nxt = S_SG2;
      S_SG2: state_nxt = S_SG3;
      S_SG3: state_nxt = S_SG4;
      S_SG4: state_nxt = (seg_near || seg_far) ? S_SQ0 : S_CR0;
      S_CR0: state_nxt = S_CR1;
      S_CR1: state_nxt = S_CR2;
      S_CR2: state_nxt = S_CR3;
      S_CR3: state_nxt = S_DIV;
      S_DIV: if (div_done) state_nxt = last ? S_DONE : S_RD;
      S_HD0: state_nxt = S_HD1;
      S_HD1: state_nxt = S_HD2;
      S_HD2: state_nxt = (behind_fail || last) ? S_DONE : S_RD;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    op_nxt = op_r;
    px_nxt = px_r; py_nxt = py_r; ex_nxt = ex_r; ey_nxt = ey_r;
    qx_nxt = qx_r; qy_nxt = qy_r; ax_nxt = ax_r; ay_nxt = ay_r;
    dx_nxt = dx_r; dy_nxt = dy_r;
    len2_nxt = len2_r; acc_nxt = acc_r; t_nxt = t_r; mag_nxt = mag_r; d_nxt = d_r;
    rad2_nxt = rad2_r; beh2_nxt = beh2_r;
    idx_nxt = idx_r; count_nxt = count_r;
    best_idx_nxt = best_idx_r; best_d_nxt = best_d_r;
    found_nxt = found_r; inside_nxt = inside_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_tuser;
          px_nxt = in_px; py_nxt = in_py; ex_nxt = in_ex; ey_nxt = in_ey;
          qx_nxt = in_px; qy_nxt = in_py;
          dx_nxt = {in_ex[23], in_ex} - {in_px[23], in_px};
          dy_nxt = {in_ey[23], in_ey} - {in_py[23], in_py};
          found_nxt  = 1'b0;
          inside_nxt = 1'b1;
          idx_nxt = (in_tuser == OP_POINT) ? IDX_W'(in_start) : '0;
          if (in_tuser == OP_CLEAR) count_nxt = '0;
          if ((in_tuser == OP_APPEND) && room) count_nxt = count_r + 1'b1;
          // requests that finish at once
          if (!((in_tuser == OP_POINT) && ({1'b0, in_start} < count_r)) &&
              !((in_tuser == OP_SEGMENT) && (count_r != '0)) &&
              !((in_tuser == OP_REGION) && (count_r != '0))) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_data_nxt[8:0]   = '1;
            out_data_nxt[57:9]  = '1;
            out_data_nxt[58]    = (in_tuser == OP_REGION);
            out_data_nxt[67:59] = 9'(count_nxt);
            out_data_nxt[68]    = (in_tuser == OP_APPEND) && !room;
          end
        end
      end
      S_R1: begin
        qx_nxt = mem_x;
        qy_nxt = mem_y;
      end
      S_R2: rad2_nxt = p_r[47:0];
      S_R3: begin
        beh2_nxt = p_r[47:0];
        idx_nxt  = IDX_W'(1);
      end
      S_LN1, S_SQ1, S_SG1, S_SG3, S_HD1: acc_nxt = pext;
      S_LN2: len2_nxt = sum[DIST_W-1:0];
      S_LD: begin
        ax_nxt = mem_x;
        ay_nxt = mem_y;
      end
      S_SQ2: begin
        if (op_r == OP_REGION) begin
          if (far_out) begin
            inside_nxt = 1'b0;
          end else if (beh_en) begin
            d_nxt = sum[DIST_W-1:0];
          end else begin
            idx_nxt = idx_step;
          end
        end else begin
          if (take) begin
            found_nxt    = 1'b1;
            best_d_nxt   = pose_d;
            best_idx_nxt = 9'(idx_r);
          end
          idx_nxt = idx_step;
        end
      end
      S_SG2: t_nxt = sum[50:0];
      S_SG4: begin
        if (seg_near) begin
          qx_nxt = px_r; qy_nxt = py_r;
        end else if (seg_far) begin
          qx_nxt = ex_r; qy_nxt = ey_r;
        end else begin
          mag_nxt = diff[ACC_W-1] ? DIST_W'(-diff) : diff[DIST_W-1:0];
        end
      end
      S_CR1: acc_nxt = pext << 50;
      S_CR2: acc_nxt = acc_r + (pext << 26);
      S_CR3: div_start = 1'b1;
      S_DIV: begin
        if (div_done) begin
          if (take) begin
            found_nxt    = 1'b1;
            best_d_nxt   = pose_d;
            best_idx_nxt = 9'(idx_r);
          end
          idx_nxt = idx_step;
        end
      end
      S_HD2: begin
        if (behind_fail) inside_nxt = 1'b0;
        else             idx_nxt = idx_step;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[8:0]   = found_r ? best_idx_r : '1;
          out_data_nxt[57:9]  = found_r ? best_d_r : '1;
          out_data_nxt[58]    = (op_r == OP_REGION) && inside_r;
          out_data_nxt[67:59] = 9'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
    op_r <= op_nxt;
    px_r <= px_nxt; py_r <= py_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
    qx_r <= qx_nxt; qy_r <= qy_nxt; ax_r <= ax_nxt; ay_r <= ay_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt;
    len2_r <= len2_nxt; acc_r <= acc_nxt; p_r <= p_nxt;
    t_r <= t_nxt; mag_r <= mag_nxt; d_r <= d_nxt;
    rad2_r <= rad2_nxt; beh2_r <= beh2_nxt;
    idx_r <= idx_nxt;
    best_idx_r <= best_idx_nxt; best_d_r <= best_d_nxt;
    inside_r <= inside_nxt;
    out_data_r <= out_data_nxt;
  end

  // store never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POSES))
    else $error("pose count beyond store depth");

  // append with room grows the store by one
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == OP_APPEND) && room) |=> (count_r == $past(count_r) + 1'b1))
    else $error("append did not grow store");

  // divider result only arrives while the sequencer waits for it
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside wait state");

  // a found best pose is a stored pose
  a_best_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && (state_r != S_IDLE)) |-> ({1'b0, best_idx_r} < {1'b0, count_r}))
    else $error("best pose outside store");

  // the sequencer never leaves a result on the floor
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && !out_free) |=> (state_r == S_DONE))
    else $error("result dropped while output busy");

endmodule
`default_nettype wire
